// ===== design/gfr_pkg.sv =====
package gfr_pkg;

  // Operation codes carried in the operation field.
  localparam logic [2:0] OP_LOAD_FONT  = 3'd0;
  localparam logic [2:0] OP_DRAW       = 3'd1;
  localparam logic [2:0] OP_SET_CURSOR = 3'd2;
  localparam logic [2:0] OP_CLEAR_LINE = 3'd3;
  localparam logic [2:0] OP_READ_FRAME = 3'd4;

  // Status codes of a result.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CLIPPED = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [7:0] FIRST_SYMBOL = 8'd32;
  localparam logic [7:0] CURSOR_MAX   = 8'd255;

  typedef struct packed {
    logic [2:0]  operation;
    logic        line_select;
    logic [7:0]  symbol_code;
    logic [7:0]  cursor_column;
    logic [11:0] font_address;
    logic [7:0]  font_byte;
    logic [8:0]  frame_address;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
    logic [7:0] cursor_after;
  } rsp_t;

endpackage

// ===== design/gfr_if.sv =====
interface gfr_req_if;
  logic          valid;
  logic          ready;
  gfr_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gfr_rsp_if;
  logic          valid;
  logic          ready;
  gfr_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/glyph_to_framebuffer_renderer_top.sv =====
// Proportional text renderer into a four-page monochrome frame store.
// One request channel (req) and one result channel (rsp), both valid/ready;
// a transfer happens on a rising edge with valid and ready high. Every
// request gives exactly one result, in order.
// Requests load a font byte, draw a symbol at a line's cursor, set a
// cursor, clear a text line, or read back one frame byte.
// The block works on one request at a time. Load, set cursor and
// undefined codes go from the execute state straight to the result; a
// frame read passes a read state first, a line clear a clear state and a
// draw a draw state. A draw is paced by the single byte-wide font port:
// one glyph record byte is fetched per cycle, and each pair of column
// bytes is written as one frame entry that holds both pages of the line.
// A line clear writes one column per cycle. After reset the frame store
// is cleared entry by entry, during which req.ready stays low. The
// finished result sits in an output register; if the receiver stalls,
// the next request may be taken but its result waits until the register
// is emptied.
module glyph_to_framebuffer_renderer_top #(
  parameter int COLUMNS            = 128,
  parameter int GLYPH_COUNT        = 95,
  parameter int GLYPH_RECORD_BYTES = 25,
  parameter int GLYPH_COLUMNS      = 12
) (
  input  logic       clk,
  input  logic       rst,
  gfr_req_if.sink    req,
  gfr_rsp_if.source  rsp
);

  localparam int FRAME_DEPTH = 2 * COLUMNS;
  localparam int FA_W        = $clog2(FRAME_DEPTH);
  localparam int FONT_BYTES  = GLYPH_COUNT * GLYPH_RECORD_BYTES;
  localparam int FO_W        = $clog2(FONT_BYTES);
  localparam int K_LAST      = 2 * GLYPH_COLUMNS;
  localparam int K_W         = $clog2(K_LAST + 1);
  localparam int SUM_W       = $clog2(256 + GLYPH_COLUMNS);
  localparam int RA_W        = $clog2(4 * COLUMNS + 512);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_READ, S_CLEAR, S_DRAW, S_DONE
  } state_t;

  state_t        state;
  gfr_pkg::req_t item_q;
  logic [FA_W-1:0] cnt;
  logic [7:0]    cursor_upper;
  logic [7:0]    cursor_lower;
  logic [7:0]    rdata_q;
  logic [1:0]    status_q;
  logic          rd_hit_q;
  logic          rd_sel_q;
  logic [FO_W-1:0] base_q;
  logic [7:0]    cur_q;
  logic [7:0]    width_q;
  logic [7:0]    upper_q;
  logic [K_W-1:0] k;
  logic [K_W-1:0] kd;
  logic          kd_valid;
  logic          kin_d;
  logic          issue_done;

  logic            frame_we;
  logic [FA_W-1:0] frame_waddr;
  logic [15:0]     frame_wdata;
  logic            frame_re;
  logic [FA_W-1:0] frame_raddr;
  logic [15:0]     frame_rdata;
  logic            font_we;
  logic [FO_W-1:0] font_waddr;
  logic            font_re;
  logic [FO_W-1:0] font_raddr;
  logic [7:0]      font_rdata;

  logic [7:0]      cur_sel;
  logic [FA_W-1:0] line_base;
  logic            sym_ok;
  logic [7:0]      sym_idx;
  logic            clip;
  logic            faddr_ok;
  logic [RA_W-1:0] ra;
  logic            rd_hit;
  logic            rd_sel;
  logic [FA_W-1:0] rd_entry;
  logic            k_in_rec;
  logic [7:0]      font_byte_d;
  logic [SUM_W-1:0] draw_col;
  logic [8:0]      adv_sum;
  logic [7:0]      adv_sat;

  assign req.ready = (state == S_IDLE);

  assign cur_sel   = item_q.line_select ? cursor_lower : cursor_upper;
  assign line_base = item_q.line_select ? FA_W'(COLUMNS) : '0;
  assign sym_idx   = item_q.symbol_code - gfr_pkg::FIRST_SYMBOL;
  assign sym_ok    = (item_q.symbol_code >= gfr_pkg::FIRST_SYMBOL) &&
                     ({1'b0, item_q.symbol_code} < 9'(32 + GLYPH_COUNT));
  assign clip      = (SUM_W'(cur_sel) + SUM_W'(GLYPH_COLUMNS)) > SUM_W'(COLUMNS);
  assign faddr_ok  = int'(item_q.font_address) < FONT_BYTES;

  // A frame byte index names a page and a column; pages 0 and 2 sit in the
  // low byte of an entry, pages 1 and 3 in the high byte.
  assign ra = RA_W'(item_q.frame_address);
  always_comb begin
    rd_hit   = 1'b1;
    rd_sel   = 1'b0;
    rd_entry = '0;
    if (ra < RA_W'(COLUMNS)) begin
      rd_entry = FA_W'(ra);
    end else if (ra < RA_W'(2 * COLUMNS)) begin
      rd_sel   = 1'b1;
      rd_entry = FA_W'(ra - RA_W'(COLUMNS));
    end else if (ra < RA_W'(3 * COLUMNS)) begin
      rd_entry = FA_W'(ra - RA_W'(COLUMNS));
    end else if (ra < RA_W'(4 * COLUMNS)) begin
      rd_sel   = 1'b1;
      rd_entry = FA_W'(ra - RA_W'(2 * COLUMNS));
    end else begin
      rd_hit   = 1'b0;
    end
  end

  // Record bytes past the end of a short record read as zero.
  assign k_in_rec    = int'(k) < GLYPH_RECORD_BYTES;
  assign font_byte_d = kin_d ? font_rdata : 8'd0;
  assign draw_col    = SUM_W'(cur_q) + SUM_W'(kd >> 1) - SUM_W'(1);
  assign adv_sum     = {1'b0, cur_q} + {1'b0, width_q};
  assign adv_sat     = adv_sum[8] ? gfr_pkg::CURSOR_MAX : adv_sum[7:0];

  always_comb begin
    frame_we    = 1'b0;
    frame_waddr = '0;
    frame_wdata = '0;
    frame_re    = 1'b0;
    frame_raddr = rd_entry;
    font_we     = 1'b0;
    font_waddr  = FO_W'(item_q.font_address);
    font_re     = 1'b0;
    font_raddr  = base_q + FO_W'(k);
    case (state)
      S_INIT: begin
        frame_we    = 1'b1;
        frame_waddr = cnt;
      end
      S_EXEC: begin
        case (item_q.operation)
          gfr_pkg::OP_LOAD_FONT: font_we = faddr_ok;
          gfr_pkg::OP_READ_FRAME: frame_re = rd_hit;
          default: ;
        endcase
      end
      S_CLEAR: begin
        frame_we    = 1'b1;
        frame_waddr = line_base + cnt;
      end
      S_DRAW: begin
        font_re     = !issue_done && k_in_rec;
        frame_we    = kd_valid && !kd[0] && (kd != '0) &&
                      (draw_col < SUM_W'(COLUMNS));
        frame_waddr = line_base + FA_W'(draw_col);
        frame_wdata = {font_byte_d, upper_q};
      end
      default: ;
    endcase
  end

  gfr_ram #(.WIDTH(16), .DEPTH(FRAME_DEPTH)) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .re    (frame_re),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  gfr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (item_q.font_byte),
    .re    (font_re),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      cnt          <= '0;
      cursor_upper <= '0;
      cursor_lower <= '0;
      rsp.valid    <= 1'b0;
      k            <= '0;
      kd_valid     <= 1'b0;
      issue_done   <= 1'b0;
    end else begin
      // The done state refills the output register itself.
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          cnt <= cnt + FA_W'(1);
          if (cnt == FA_W'(FRAME_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            item_q <= req.data;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          rdata_q    <= 8'd0;
          rd_hit_q   <= rd_hit;
          rd_sel_q   <= rd_sel;
          cnt        <= '0;
          k          <= '0;
          kd_valid   <= 1'b0;
          issue_done <= 1'b0;
          base_q     <= FO_W'(32'(sym_idx) * GLYPH_RECORD_BYTES);
          cur_q      <= cur_sel;
          case (item_q.operation)
            gfr_pkg::OP_DRAW: begin
              if (!sym_ok) begin
                status_q <= gfr_pkg::ST_RANGE;
                state    <= S_DONE;
              end else begin
                status_q <= clip ? gfr_pkg::ST_CLIPPED : gfr_pkg::ST_OK;
                state    <= S_DRAW;
              end
            end
            gfr_pkg::OP_SET_CURSOR: begin
              status_q <= gfr_pkg::ST_OK;
              state    <= S_DONE;
              if (item_q.line_select) begin
                cursor_lower <= item_q.cursor_column;
              end else begin
                cursor_upper <= item_q.cursor_column;
              end
            end
            gfr_pkg::OP_CLEAR_LINE: begin
              status_q <= gfr_pkg::ST_OK;
              state    <= S_CLEAR;
            end
            gfr_pkg::OP_READ_FRAME: begin
              status_q <= gfr_pkg::ST_OK;
              state    <= S_READ;
            end
            default: begin
              status_q <= gfr_pkg::ST_OK;
              state    <= S_DONE;
            end
          endcase
        end
        S_READ: begin
          if (rd_hit_q) begin
            rdata_q <= rd_sel_q ? frame_rdata[15:8] : frame_rdata[7:0];
          end
          state <= S_DONE;
        end
        S_CLEAR: begin
          cnt <= cnt + FA_W'(1);
          if (cnt == FA_W'(COLUMNS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DRAW: begin
          // Fetch side: one record byte per cycle; data side follows in the next cycle.
          kd       <= k;
          kin_d    <= k_in_rec;
          kd_valid <= !issue_done;
          if (!issue_done) begin
            k <= k + K_W'(1);
            if (k == K_W'(K_LAST)) begin
              issue_done <= 1'b1;
            end
          end
          if (kd_valid) begin
            if (kd == '0) begin
              width_q <= font_byte_d;
            end else if (kd[0]) begin
              upper_q <= font_byte_d;
            end
            if (kd == K_W'(K_LAST)) begin
              if (item_q.line_select) begin
                cursor_lower <= adv_sat;
              end else begin
                cursor_upper <= adv_sat;
              end
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid             <= 1'b1;
            rsp.data.read_data    <= rdata_q;
            rsp.data.status       <= status_q;
            rsp.data.cursor_after <= cur_sel;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The frame store is written only while an operation or the reset sweep runs.
  assert property (@(posedge clk) disable iff (rst)
    frame_we |-> (state != S_IDLE && state != S_DONE))
    else $error("frame store written outside an operation");

  // No request is taken in the first cycle after reset: the sweep runs first.
  assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !req.ready)
    else $error("request taken before the frame store was cleared");

  // An out-of-range status is only ever produced by a draw.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && status_q == gfr_pkg::ST_RANGE) |->
      (item_q.operation == gfr_pkg::OP_DRAW))
    else $error("range status on an operation other than draw");

  // Cursors only move while an operation is being carried out.
  assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC && state != S_DRAW) |=>
      ($stable(cursor_upper) && $stable(cursor_lower)))
    else $error("cursor changed outside an operation");

  // Glyph fetches stay inside the font store.
  assert property (@(posedge clk) disable iff (rst)
    font_re |-> (int'(font_raddr) < FONT_BYTES))
    else $error("font fetch beyond the font store");

endmodule

// ===== design/gfr_ram.sv =====
module gfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
